// ----- rtl/bim_pkg.sv -----
// bim_pkg: widths, register indexes and the pipeline item type for the
// broadcast index mapper. No dependencies.
package bim_pkg;

	localparam int IDX_W        = 32;   // index and stride width
	localparam int SIZE_W       = 16;   // input size width
	localparam int REG_DIMS     = 4;    // dimensions backed by registers
	localparam int MAX_DIMS_DEF = 4;
	localparam int CFG_IDX_W    = 4;    // wide enough to see writes past the list
	localparam int CFG_DATA_W   = 32;
	localparam int DIM_SEL_W    = $clog2(REG_DIMS);

	// register map
	localparam logic [CFG_IDX_W-1:0] REG_STRIDE_BASE = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_BASE   = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_END         = 4'd8;

	// pipeline depth of one dimension: one divide step per bit, multiply, add
	localparam int DIM_LAT = IDX_W + 2;

	typedef struct packed {
		logic             vld;
		logic [IDX_W-1:0] rest;   // index still to be split
		logic [IDX_W-1:0] src;    // source index built so far
	} bim_item_t;

endpackage

// ----- rtl/broadcast_index_mapper.sv -----
// broadcast_index_mapper: top level. Configuration registers and a chain of
// bim_dim units, one per dimension. Uses bim_pkg and bim_dim.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+------------------------------
//  item in   | start (taken when !busy)  | out_index
//  result    | done strobe, one cycle    | src_index
//  config    | cfg_we                    | cfg_index, cfg_wdata
//
// An item is taken every cycle; busy stays low.
// Each dimension runs through 32 divide steps, one multiply and one add; the
// bit-serial divide sets the depth.
// Reset clears the pipeline valid bits and sets every config register to 1.
// The receiver cannot stall, so the pipeline never holds and drops nothing.
module broadcast_index_mapper #(
	parameter int MAX_DIMS = bim_pkg::MAX_DIMS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [bim_pkg::IDX_W-1:0]      out_index,
	output logic                          done,
	output logic [bim_pkg::IDX_W-1:0]      src_index,
	input  logic                          cfg_we,
	input  logic [bim_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bim_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import bim_pkg::*;

	// only dimensions that have registers are walked
	localparam int NUM_DIMS = (MAX_DIMS < REG_DIMS) ? MAX_DIMS : REG_DIMS;

	logic [IDX_W-1:0]  stride_q [REG_DIMS];
	logic [SIZE_W-1:0] size_q   [REG_DIMS];

	// register writes; indexes past the list fall through untouched
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < REG_DIMS; d++) begin
				stride_q[d] <= IDX_W'(1);
				size_q[d]   <= SIZE_W'(1);
			end
		end else if (cfg_we) begin
			if (cfg_index < REG_SIZE_BASE) begin
				stride_q[cfg_index[DIM_SEL_W-1:0]] <= cfg_wdata[IDX_W-1:0];
			end else if (cfg_index < REG_END) begin
				size_q[cfg_index[DIM_SEL_W-1:0]] <= cfg_wdata[SIZE_W-1:0];
			end
		end
	end

	// item chain: entry 0 straight from the ports, entry d+1 out of dimension d
	bim_item_t chain [NUM_DIMS+1];

	assign chain[0].vld  = start && !busy;
	assign chain[0].rest = out_index;
	assign chain[0].src  = '0;

	genvar d;
	generate
		for (d = 0; d < NUM_DIMS; d++) begin : g_dim
			bim_dim u_dim (
				.clk      (clk),
				.arst_n   (arst_n),
				.stride   (stride_q[d]),
				.size_in  (size_q[d]),
				.in_item  (chain[d]),
				.out_item (chain[d+1])
			);
		end
	endgenerate

	assign busy      = 1'b0;
	assign done      = chain[NUM_DIMS].vld;
	assign src_index = chain[NUM_DIMS].src;

endmodule

// ----- rtl/bim_dim.sv -----
// bim_dim: one dimension of the mapper. Bit-serial restoring divide over
// 32 stages, then a multiply stage and a saturating add stage. Uses bim_pkg.
module bim_dim (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [bim_pkg::IDX_W-1:0]  stride,
	input  logic [bim_pkg::SIZE_W-1:0] size_in,
	input  bim_pkg::bim_item_t         in_item,
	output bim_pkg::bim_item_t         out_item
);
	import bim_pkg::*;

	localparam int STEPS = IDX_W;

	logic [IDX_W-1:0] rem_s [STEPS];
	logic [IDX_W-1:0] dq_s  [STEPS];   // dividend bits out the top, quotient in the bottom
	logic [IDX_W-1:0] src_s [STEPS];
	logic             vld_s [STEPS];

	genvar k;
	generate
		for (k = 0; k < STEPS; k++) begin : g_step
			logic [IDX_W-1:0] rem_i;
			logic [IDX_W-1:0] dq_i;
			logic [IDX_W-1:0] src_i;
			logic             vld_i;
			logic [IDX_W:0]   trial;
			logic             ge;

			if (k == 0) begin : g_first
				assign rem_i = '0;
				assign dq_i  = in_item.rest;
				assign src_i = in_item.src;
				assign vld_i = in_item.vld;
			end else begin : g_next
				assign rem_i = rem_s[k-1];
				assign dq_i  = dq_s[k-1];
				assign src_i = src_s[k-1];
				assign vld_i = vld_s[k-1];
			end

			assign trial = {rem_i, dq_i[IDX_W-1]};
			// zero stride: never subtract, so digit is 0 and rest comes out whole
			assign ge = (stride != '0) && (trial >= {1'b0, stride});

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k] <= 1'b0;
				end else begin
					vld_s[k] <= vld_i;
				end
			end

			always_ff @(posedge clk) begin
				rem_s[k] <= ge ? IDX_W'(trial - {1'b0, stride}) : trial[IDX_W-1:0];
				dq_s[k]  <= {dq_i[IDX_W-2:0], ge};
				src_s[k] <= src_i;
			end
		end
	endgenerate

	// multiply stage
	logic [IDX_W+SIZE_W-1:0] prod_s1;
	logic [IDX_W-1:0]        digit_s1;
	logic [IDX_W-1:0]        rest_s1;
	logic                    vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld_s[STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		prod_s1  <= src_s[STEPS-1] * size_in;
		digit_s1 <= dq_s[STEPS-1];
		rest_s1  <= rem_s[STEPS-1];
	end

	// add and saturate stage
	logic [IDX_W:0] sum;
	logic           sat;

	assign sum = {1'b0, prod_s1[IDX_W-1:0]}
		+ ((size_in > SIZE_W'(1)) ? {1'b0, digit_s1} : '0);
	assign sat = (prod_s1[IDX_W+SIZE_W-1:IDX_W] != '0) || sum[IDX_W];

	logic             vld_s2;
	logic [IDX_W-1:0] rest_s2;
	logic [IDX_W-1:0] src_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		rest_s2 <= rest_s1;
		src_s2  <= sat ? '1 : sum[IDX_W-1:0];
	end

	assign out_item = '{vld: vld_s2, rest: rest_s2, src: src_s2};

endmodule

// ----- rtl/bim_checker.sv -----
// bim_checker: port-level checks for broadcast_index_mapper, bound to the top.
// Uses bim_pkg.
module bim_checker #(
	parameter int MAX_DIMS = bim_pkg::MAX_DIMS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);
	import bim_pkg::*;

	localparam int NUM_DIMS = (MAX_DIMS < REG_DIMS) ? MAX_DIMS : REG_DIMS;
	localparam int LAT      = NUM_DIMS * DIM_LAT;
	localparam int CNT_W    = $clog2(LAT + 1);

	// cycles since reset, saturating at the latency
	logic [CNT_W-1:0] warm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warm_q <= '0;
		end else if (warm_q != CNT_W'(LAT)) begin
			warm_q <= warm_q + CNT_W'(1);
		end
	end

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_no_early_done: assert property (@(posedge clk) disable iff (!arst_n)
		(warm_q != CNT_W'(LAT)) |-> !done)
		else $error("result before any item could finish");

	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(warm_q == CNT_W'(LAT)) |-> (done == $past(start && !busy, LAT)))
		else $error("result strobe does not match an accepted item");

endmodule

bind broadcast_index_mapper bim_checker #(.MAX_DIMS(MAX_DIMS)) u_bim_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);
